### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms used by the odometer rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds on every clock edge out of reset
`define THODO_ASSERT_ALW(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define THODO_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define THODO_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### src/thodo_pkg.sv
// ----------------------------------------------------------------------------
// thodo_pkg
// types, fixed-point constants and the arctangent table of the odometer
// ----------------------------------------------------------------------------
`default_nettype none

package thodo_pkg;

   localparam int DW       = 40;
   localparam int PW       = 2 * DW;
   localparam int FRAC     = 30;
   localparam int NUM_ITER = 32;
   localparam int IDX_W    = $clog2(NUM_ITER);
   localparam int A_W      = FRAC + 1;

   localparam logic signed [DW-1:0] KINV    = 40'sd652032874;
   localparam logic signed [DW-1:0] PI_F    = 40'sd3373259428;
   localparam logic signed [DW-1:0] HALF_PI = 40'sd1686629714;
   localparam logic signed [DW-1:0] TWO_PI  = 40'sd6746518856;
   localparam logic signed [DW-1:0] ONE_F   = 40'sd1073741824;
   localparam logic signed [DW-1:0] RAD_K   = 40'sd8048910509;

   localparam logic [22:0] RADIUS_RESET = 23'd6371003;

   typedef enum logic [3:0] {
      STEP_RAD_DLAT = 4'd0,
      STEP_SC_DLAT  = 4'd1,
      STEP_RAD_DLON = 4'd2,
      STEP_SC_DLON  = 4'd3,
      STEP_RAD_LAT1 = 4'd4,
      STEP_SC_LAT1  = 4'd5,
      STEP_RAD_LAT2 = 4'd6,
      STEP_SC_LAT2  = 4'd7,
      STEP_SQ_DLAT  = 4'd8,
      STEP_C1C2     = 4'd9,
      STEP_SQ_DLON  = 4'd10,
      STEP_PROD     = 4'd11,
      STEP_ROOT_Y   = 4'd12,
      STEP_ROOT_X   = 4'd13,
      STEP_ATAN     = 4'd14,
      STEP_SCALE    = 4'd15
   } step_type;

   typedef enum logic [1:0] {
      SHIFT_FRAC = 2'd0,
      SHIFT_FULL = 2'd1,
      SHIFT_HALF = 2'd2
   } shift_type;

   typedef enum logic {
      MODE_ROTATE = 1'b0,
      MODE_VECTOR = 1'b1
   } cordic_mode_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   // atan(2^-i) in q30, rounded
   function automatic logic signed [DW-1:0] atan_entry(input logic [IDX_W-1:0] idx);
      logic signed [DW-1:0] val;
      begin
         case (idx)
            5'd0:    val = 40'sd843314857;
            5'd1:    val = 40'sd497837829;
            5'd2:    val = 40'sd263043837;
            5'd3:    val = 40'sd133525159;
            5'd4:    val = 40'sd67021687;
            5'd5:    val = 40'sd33543516;
            5'd6:    val = 40'sd16775851;
            5'd7:    val = 40'sd8388437;
            5'd8:    val = 40'sd4194283;
            5'd9:    val = 40'sd2097149;
            5'd30:   val = 40'sd1;
            5'd31:   val = 40'sd1;
            default: val = DW'(1) <<< (FRAC - int'(idx));
         endcase
         return val;
      end
   endfunction

endpackage

`default_nettype wire

### src/thodo_mul.sv
// ----------------------------------------------------------------------------
// thodo_mul
// shift-add multiplier, sign-magnitude, rounded right shift of the product
// ----------------------------------------------------------------------------
`default_nettype none

module thodo_mul import thodo_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic signed [DW-1:0] a_val,
   input  wire logic signed [DW-1:0] b_val,
   input  wire shift_type            shift_sel,
   output unit_stat_type             stat,
   output logic signed [DW-1:0]      result
);

   typedef enum logic [3:0] {
      MS_IDLE = 4'b0001,
      MS_ACC  = 4'b0010,
      MS_RND  = 4'b0100,
      MS_SGN  = 4'b1000
   } mul_state_type;

   localparam int CNT_W = $clog2(DW);

   mul_state_type        state_ff, state_in;
   logic [PW-1:0]        acc_ff, acc_in;
   logic [PW-1:0]        ash_ff, ash_in;
   logic [DW-1:0]        bsh_ff, bsh_in;
   logic                 neg_ff, neg_in;
   shift_type            sel_ff, sel_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DW-1:0]        mag_ff, mag_in;
   logic signed [DW-1:0] res_ff, res_in;
   logic                 done_ff, done_in;

   logic [DW-1:0] a_mag, b_mag;
   logic [5:0]    shamt;
   logic [PW-1:0] rnd;

   always_comb begin
      a_mag = a_val[DW-1] ? DW'(-a_val) : DW'(a_val);
      b_mag = b_val[DW-1] ? DW'(-b_val) : DW'(b_val);
      case (sel_ff)
         SHIFT_FRAC: shamt = 6'(FRAC);
         SHIFT_FULL: shamt = 6'(FRAC + 2);
         SHIFT_HALF: shamt = 6'(FRAC + 3);
         default:    shamt = 6'(FRAC);
      endcase
      rnd = acc_ff + (PW'(1) << (shamt - 6'd1));
   end

   always_comb begin
      state_in = state_ff;
      acc_in   = acc_ff;
      ash_in   = ash_ff;
      bsh_in   = bsh_ff;
      neg_in   = neg_ff;
      sel_in   = sel_ff;
      cnt_in   = cnt_ff;
      mag_in   = mag_ff;
      res_in   = res_ff;
      done_in  = 1'b0;
      case (state_ff)
         MS_IDLE: begin
            if (start) begin
               acc_in   = '0;
               ash_in   = PW'(a_mag);
               bsh_in   = b_mag;
               neg_in   = a_val[DW-1] ^ b_val[DW-1];
               sel_in   = shift_sel;
               cnt_in   = '0;
               state_in = MS_ACC;
            end
         end
         MS_ACC: begin
            if (bsh_ff[0]) begin
               acc_in = acc_ff + ash_ff;
            end
            ash_in = ash_ff << 1;
            bsh_in = bsh_ff >> 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DW - 1)) begin
               state_in = MS_RND;
            end
         end
         MS_RND: begin
            mag_in   = DW'(rnd >> shamt);
            state_in = MS_SGN;
         end
         MS_SGN: begin
            res_in   = neg_ff ? -$signed(mag_ff) : $signed(mag_ff);
            done_in  = 1'b1;
            state_in = MS_IDLE;
         end
         default: state_in = MS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      acc_ff <= acc_in;
      ash_ff <= ash_in;
      bsh_ff <= bsh_in;
      neg_ff <= neg_in;
      sel_ff <= sel_in;
      cnt_ff <= cnt_in;
      mag_ff <= mag_in;
      res_ff <= res_in;
   end

   assign stat.busy = (state_ff != MS_IDLE);
   assign stat.done = done_ff;
   assign result    = res_ff;

endmodule

`default_nettype wire

### src/thodo_cordic.sv
// ----------------------------------------------------------------------------
// thodo_cordic
// cordic unit, rotation for sine and cosine, vectoring for the arctangent
// ----------------------------------------------------------------------------
`default_nettype none

module thodo_cordic import thodo_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire cordic_mode_type      mode,
   input  wire logic signed [DW-1:0] angle,
   input  wire logic signed [DW-1:0] x_init,
   input  wire logic signed [DW-1:0] y_init,
   output unit_stat_type             stat,
   output logic signed [DW-1:0]      sin_out,
   output logic signed [DW-1:0]      cos_out,
   output logic signed [DW-1:0]      z_out
);

   typedef enum logic [3:0] {
      CS_IDLE = 4'b0001,
      CS_WRAP = 4'b0010,
      CS_FOLD = 4'b0100,
      CS_ITER = 4'b1000
   } cordic_state_type;

   cordic_state_type     state_ff, state_in;
   cordic_mode_type      mode_ff, mode_in;
   logic signed [DW-1:0] x_ff, x_in;
   logic signed [DW-1:0] y_ff, y_in;
   logic signed [DW-1:0] z_ff, z_in;
   logic                 flip_ff, flip_in;
   logic [IDX_W-1:0]     cnt_ff, cnt_in;
   logic                 done_ff, done_in;

   logic signed [DW-1:0] xs, ys, at;
   logic                 sigma;

   always_comb begin
      xs    = x_ff >>> cnt_ff;
      ys    = y_ff >>> cnt_ff;
      at    = atan_entry(cnt_ff);
      sigma = (mode_ff == MODE_ROTATE) ? !z_ff[DW-1] : y_ff[DW-1];
   end

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      flip_in  = flip_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      case (state_ff)
         CS_IDLE: begin
            if (start) begin
               mode_in = mode;
               flip_in = 1'b0;
               cnt_in  = '0;
               if (mode == MODE_ROTATE) begin
                  x_in     = KINV;
                  y_in     = '0;
                  z_in     = angle;
                  state_in = CS_WRAP;
               end else begin
                  x_in     = x_init;
                  y_in     = y_init;
                  z_in     = '0;
                  state_in = CS_ITER;
               end
            end
         end
         CS_WRAP: begin
            if (z_ff > PI_F) begin
               z_in = z_ff - TWO_PI;
            end else if (z_ff < -PI_F) begin
               z_in = z_ff + TWO_PI;
            end
            state_in = CS_FOLD;
         end
         CS_FOLD: begin
            if (z_ff > HALF_PI) begin
               z_in    = PI_F - z_ff;
               flip_in = 1'b1;
            end else if (z_ff < -HALF_PI) begin
               z_in    = -PI_F - z_ff;
               flip_in = 1'b1;
            end
            state_in = CS_ITER;
         end
         CS_ITER: begin
            if (sigma) begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - at;
            end else begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + at;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == IDX_W'(NUM_ITER - 1)) begin
               done_in  = 1'b1;
               state_in = CS_IDLE;
            end
         end
         default: state_in = CS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      mode_ff <= mode_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      flip_ff <= flip_in;
      cnt_ff  <= cnt_in;
   end

   assign stat.busy = (state_ff != CS_IDLE);
   assign stat.done = done_ff;
   assign sin_out   = y_ff;
   assign cos_out   = flip_ff ? -x_ff : x_ff;
   assign z_out     = z_ff;

endmodule

`default_nettype wire

### src/thodo_isqrt.sv
// ----------------------------------------------------------------------------
// thodo_isqrt
// floor square root of a 64-bit value, two radicand bits per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module thodo_isqrt import thodo_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] radicand,
   output unit_stat_type    stat,
   output logic [31:0]      root
);

   typedef enum logic [1:0] {
      QS_IDLE = 2'b01,
      QS_ITER = 2'b10
   } sqrt_state_type;

   sqrt_state_type state_ff, state_in;
   logic [63:0]    v_ff, v_in;
   logic [63:0]    res_ff, res_in;
   logic [63:0]    bit_ff, bit_in;
   logic [4:0]     cnt_ff, cnt_in;
   logic           done_ff, done_in;

   logic [64:0] trial;

   assign trial = {1'b0, res_ff} + {1'b0, bit_ff};

   always_comb begin
      state_in = state_ff;
      v_in     = v_ff;
      res_in   = res_ff;
      bit_in   = bit_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      case (state_ff)
         QS_IDLE: begin
            if (start) begin
               v_in     = radicand;
               res_in   = '0;
               bit_in   = 64'd1 << 62;
               cnt_in   = '0;
               state_in = QS_ITER;
            end
         end
         QS_ITER: begin
            if ({1'b0, v_ff} >= trial) begin
               v_in   = 64'({1'b0, v_ff} - trial);
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 5'd31) begin
               done_in  = 1'b1;
               state_in = QS_IDLE;
            end
         end
         default: state_in = QS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= QS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      v_ff   <= v_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      cnt_ff <= cnt_in;
   end

   assign stat.busy = (state_ff != QS_IDLE);
   assign stat.done = done_ff;
   assign root      = res_ff[31:0];

endmodule

`default_nettype wire

### src/track_haversine_odometer.sv
// for a point with a predecessor, the result is computed by nine serial multiplies,
//    five 32-step cordic passes and two root passes
// the first accepted point skips the arithmetic and goes straight to the done state
// a point at zero latitude and longitude is taken and gives no result
// throughput: one point at a time, the next is taken while the last result waits
// reset (synchronous): totals and history cleared, radius back to 6371003 m
// ----------------------------------------------------------------------------
// track_haversine_odometer
// gps track odometer: haversine distance, ascent and descent totals
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module track_haversine_odometer import thodo_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [30:0] req_latitude,
   input  wire logic signed [31:0] req_longitude,
   input  wire logic               req_elevation_valid,
   input  wire logic signed [24:0] req_elevation_mm,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [47:0]             rsp_distance_mm,
   output logic [39:0]             rsp_ascent_mm,
   output logic [39:0]             rsp_descent_mm,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [22:0]        csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_DONE = 3'b100
   } top_state_type;

   localparam logic [47:0] DIST_MAX = '1;
   localparam logic [39:0] ELEV_MAX = '1;

   top_state_type        state_ff, state_in;
   step_type             step_ff, step_in;
   logic                 wait_ff, wait_in;
   logic [22:0]          radius_ff, radius_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic signed [30:0]   cur_lat_ff, cur_lat_in;
   logic signed [31:0]   cur_lon_ff, cur_lon_in;
   logic                 cur_ev_ff, cur_ev_in;
   logic signed [24:0]   cur_elev_ff, cur_elev_in;

   logic                 have_prev_ff, have_prev_in;
   logic signed [30:0]   prev_lat_ff, prev_lat_in;
   logic signed [31:0]   prev_lon_ff, prev_lon_in;
   logic                 prev_has_elev_ff, prev_has_elev_in;
   logic signed [24:0]   prev_elev_ff, prev_elev_in;
   logic [47:0]          distance_ff, distance_in;
   logic [39:0]          ascent_ff, ascent_in;
   logic [39:0]          descent_ff, descent_in;

   logic signed [DW-1:0] ang_ff, ang_in;
   logic signed [DW-1:0] s_lat_ff, s_lat_in;
   logic signed [DW-1:0] s_lon_ff, s_lon_in;
   logic signed [DW-1:0] c1_ff, c1_in;
   logic signed [DW-1:0] c2_ff, c2_in;
   logic signed [DW-1:0] t1_ff, t1_in;
   logic signed [DW-1:0] t2_ff, t2_in;
   logic signed [DW-1:0] t3_ff, t3_in;
   logic [A_W-1:0]       a_ff, a_in;
   logic [31:0]          root_y_ff, root_y_in;
   logic [31:0]          root_x_ff, root_x_in;
   logic signed [DW-1:0] zc_ff, zc_in;
   logic [DW-1:0]        seg_ff, seg_in;

   unit_stat_type        mul_stat, cor_stat, sq_stat;
   logic signed [DW-1:0] mul_a, mul_b, mul_res;
   shift_type            mul_sel;
   logic                 mul_start, cor_start, sq_start;
   cordic_mode_type      cor_mode;
   logic signed [DW-1:0] cor_sin, cor_cos, cor_z;
   logic [63:0]          sq_rad;
   logic [31:0]          sq_root;

   logic                 req_acc, zero_pt, issue, any_done, finish;
   logic                 is_mul, is_cor, is_sq;
   logic signed [DW-1:0] dlat, dlon, r1000, a_sum, z2;
   logic [A_W-1:0]       one_minus_a;
   logic [48:0]          dist_sum;
   logic signed [25:0]   ediff;
   logic [25:0]          emag;
   logic [40:0]          elev_sum;

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign zero_pt   = (req_latitude == '0) && (req_longitude == '0);
   assign issue     = (state_ff == ST_RUN) && !wait_ff;
   assign any_done  = mul_stat.done || cor_stat.done || sq_stat.done;
   assign finish    = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   assign dlat  = DW'(cur_lat_ff) - DW'(prev_lat_ff);
   assign dlon  = DW'(cur_lon_ff) - DW'(prev_lon_ff);
   assign r1000 = (DW'(radius_ff) << 10) - (DW'(radius_ff) << 4) - (DW'(radius_ff) << 3);
   assign a_sum = t1_ff + mul_res;
   assign z2    = cor_z <<< 1;
   assign one_minus_a = A_W'(ONE_F) - a_ff;

   // unit and operand selection per step
   always_comb begin
      is_mul   = 1'b0;
      is_cor   = 1'b0;
      is_sq    = 1'b0;
      mul_a    = dlat;
      mul_b    = RAD_K;
      mul_sel  = SHIFT_HALF;
      cor_mode = MODE_ROTATE;
      sq_rad   = {1'b0, a_ff, 32'd0};
      case (step_ff)
         STEP_RAD_DLAT: begin
            is_mul = 1'b1;
         end
         STEP_RAD_DLON: begin
            is_mul = 1'b1;
            mul_a  = dlon;
         end
         STEP_RAD_LAT1: begin
            is_mul  = 1'b1;
            mul_a   = DW'(prev_lat_ff);
            mul_sel = SHIFT_FULL;
         end
         STEP_RAD_LAT2: begin
            is_mul  = 1'b1;
            mul_a   = DW'(cur_lat_ff);
            mul_sel = SHIFT_FULL;
         end
         STEP_SC_DLAT, STEP_SC_DLON, STEP_SC_LAT1, STEP_SC_LAT2: begin
            is_cor = 1'b1;
         end
         STEP_SQ_DLAT: begin
            is_mul  = 1'b1;
            mul_a   = s_lat_ff;
            mul_b   = s_lat_ff;
            mul_sel = SHIFT_FRAC;
         end
         STEP_C1C2: begin
            is_mul  = 1'b1;
            mul_a   = c1_ff;
            mul_b   = c2_ff;
            mul_sel = SHIFT_FRAC;
         end
         STEP_SQ_DLON: begin
            is_mul  = 1'b1;
            mul_a   = s_lon_ff;
            mul_b   = s_lon_ff;
            mul_sel = SHIFT_FRAC;
         end
         STEP_PROD: begin
            is_mul  = 1'b1;
            mul_a   = t2_ff;
            mul_b   = t3_ff;
            mul_sel = SHIFT_FRAC;
         end
         STEP_ROOT_Y: begin
            is_sq = 1'b1;
         end
         STEP_ROOT_X: begin
            is_sq  = 1'b1;
            sq_rad = {1'b0, one_minus_a, 32'd0};
         end
         STEP_ATAN: begin
            is_cor   = 1'b1;
            cor_mode = MODE_VECTOR;
         end
         STEP_SCALE: begin
            is_mul  = 1'b1;
            mul_a   = zc_ff;
            mul_b   = r1000;
            mul_sel = SHIFT_FRAC;
         end
         default: is_mul = 1'b0;
      endcase
   end

   assign mul_start = issue && is_mul;
   assign cor_start = issue && is_cor;
   assign sq_start  = issue && is_sq;

   thodo_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .start     (mul_start),
      .a_val     (mul_a),
      .b_val     (mul_b),
      .shift_sel (mul_sel),
      .stat      (mul_stat),
      .result    (mul_res)
   );

   thodo_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_start),
      .mode    (cor_mode),
      .angle   (ang_ff),
      .x_init  (DW'(root_x_ff)),
      .y_init  (DW'(root_y_ff)),
      .stat    (cor_stat),
      .sin_out (cor_sin),
      .cos_out (cor_cos),
      .z_out   (cor_z)
   );

   thodo_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (sq_rad),
      .stat     (sq_stat),
      .root     (sq_root)
   );

   // totals update
   always_comb begin
      dist_sum = {1'b0, distance_ff} + 49'(seg_ff);
      ediff    = 26'(cur_elev_ff) - 26'(prev_elev_ff);
      emag     = (ediff > 26'sd0) ? 26'(ediff) : 26'(-ediff);
      elev_sum = (ediff > 26'sd0) ? ({1'b0, ascent_ff} + 41'(emag))
                                  : ({1'b0, descent_ff} + 41'(emag));
   end

   always_comb begin
      state_in         = state_ff;
      step_in          = step_ff;
      wait_in          = wait_ff;
      radius_in        = radius_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      cur_lat_in       = cur_lat_ff;
      cur_lon_in       = cur_lon_ff;
      cur_ev_in        = cur_ev_ff;
      cur_elev_in      = cur_elev_ff;
      have_prev_in     = have_prev_ff;
      prev_lat_in      = prev_lat_ff;
      prev_lon_in      = prev_lon_ff;
      prev_has_elev_in = prev_has_elev_ff;
      prev_elev_in     = prev_elev_ff;
      distance_in      = distance_ff;
      ascent_in        = ascent_ff;
      descent_in       = descent_ff;
      ang_in           = ang_ff;
      s_lat_in         = s_lat_ff;
      s_lon_in         = s_lon_ff;
      c1_in            = c1_ff;
      c2_in            = c2_ff;
      t1_in            = t1_ff;
      t2_in            = t2_ff;
      t3_in            = t3_ff;
      a_in             = a_ff;
      root_y_in        = root_y_ff;
      root_x_in        = root_x_ff;
      zc_in            = zc_ff;
      seg_in           = seg_ff;

      if (csr_valid && csr_ready) begin
         radius_in = csr_wdata;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc && !zero_pt) begin
               cur_lat_in  = req_latitude;
               cur_lon_in  = req_longitude;
               cur_ev_in   = req_elevation_valid;
               cur_elev_in = req_elevation_mm;
               step_in     = STEP_RAD_DLAT;
               wait_in     = 1'b0;
               state_in    = have_prev_ff ? ST_RUN : ST_DONE;
            end
         end
         ST_RUN: begin
            if (issue) begin
               wait_in = 1'b1;
            end
            if (any_done) begin
               wait_in = 1'b0;
               case (step_ff)
                  STEP_RAD_DLAT, STEP_RAD_DLON, STEP_RAD_LAT1, STEP_RAD_LAT2:
                     ang_in = mul_res;
                  STEP_SC_DLAT: s_lat_in = cor_sin;
                  STEP_SC_DLON: s_lon_in = cor_sin;
                  STEP_SC_LAT1: c1_in = cor_cos;
                  STEP_SC_LAT2: c2_in = cor_cos;
                  STEP_SQ_DLAT: t1_in = mul_res;
                  STEP_C1C2:    t2_in = mul_res;
                  STEP_SQ_DLON: t3_in = mul_res;
                  STEP_PROD: begin
                     if (a_sum[DW-1]) begin
                        a_in = '0;
                     end else if (a_sum > ONE_F) begin
                        a_in = A_W'(ONE_F);
                     end else begin
                        a_in = A_W'(a_sum);
                     end
                  end
                  STEP_ROOT_Y: root_y_in = sq_root;
                  STEP_ROOT_X: root_x_in = sq_root;
                  STEP_ATAN:   zc_in = z2[DW-1] ? '0 : z2;
                  STEP_SCALE:  seg_in = DW'(mul_res);
                  default:     seg_in = seg_ff;
               endcase
               if (step_ff == STEP_SCALE) begin
                  state_in = ST_DONE;
               end else begin
                  step_in = step_type'(step_ff + 4'd1);
               end
            end
         end
         ST_DONE: begin
            if (finish) begin
               if (have_prev_ff) begin
                  distance_in = (dist_sum > {1'b0, DIST_MAX}) ? DIST_MAX : dist_sum[47:0];
                  if (cur_ev_ff && prev_has_elev_ff) begin
                     if (ediff > 26'sd0) begin
                        ascent_in = (elev_sum > {1'b0, ELEV_MAX}) ? ELEV_MAX
                                                                  : elev_sum[39:0];
                     end else begin
                        descent_in = (elev_sum > {1'b0, ELEV_MAX}) ? ELEV_MAX
                                                                   : elev_sum[39:0];
                     end
                  end
               end
               have_prev_in     = 1'b1;
               prev_lat_in      = cur_lat_ff;
               prev_lon_in      = cur_lon_ff;
               prev_has_elev_in = cur_ev_ff;
               prev_elev_in     = cur_ev_ff ? cur_elev_ff : '0;
               rsp_valid_in     = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         step_ff          <= STEP_RAD_DLAT;
         wait_ff          <= 1'b0;
         radius_ff        <= RADIUS_RESET;
         rsp_valid_ff     <= 1'b0;
         have_prev_ff     <= 1'b0;
         prev_lat_ff      <= '0;
         prev_lon_ff      <= '0;
         prev_has_elev_ff <= 1'b0;
         prev_elev_ff     <= '0;
         distance_ff      <= '0;
         ascent_ff        <= '0;
         descent_ff       <= '0;
      end else begin
         state_ff         <= state_in;
         step_ff          <= step_in;
         wait_ff          <= wait_in;
         radius_ff        <= radius_in;
         rsp_valid_ff     <= rsp_valid_in;
         have_prev_ff     <= have_prev_in;
         prev_lat_ff      <= prev_lat_in;
         prev_lon_ff      <= prev_lon_in;
         prev_has_elev_ff <= prev_has_elev_in;
         prev_elev_ff     <= prev_elev_in;
         distance_ff      <= distance_in;
         ascent_ff        <= ascent_in;
         descent_ff       <= descent_in;
      end
      cur_lat_ff  <= cur_lat_in;
      cur_lon_ff  <= cur_lon_in;
      cur_ev_ff   <= cur_ev_in;
      cur_elev_ff <= cur_elev_in;
      ang_ff      <= ang_in;
      s_lat_ff    <= s_lat_in;
      s_lon_ff    <= s_lon_in;
      c1_ff       <= c1_in;
      c2_ff       <= c2_in;
      t1_ff       <= t1_in;
      t2_ff       <= t2_in;
      t3_ff       <= t3_in;
      a_ff        <= a_in;
      root_y_ff   <= root_y_in;
      root_x_ff   <= root_x_in;
      zc_ff       <= zc_in;
      seg_ff      <= seg_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_distance_mm = distance_ff;
   assign rsp_ascent_mm   = ascent_ff;
   assign rsp_descent_mm  = descent_ff;

   // only one arithmetic unit works at a time
   `THODO_ASSERT_ALW(a_one_unit, clock, reset, $onehot0({mul_stat.busy, cor_stat.busy, sq_stat.busy}))
   // a unit finishes only while the sequencer waits for it
   `THODO_ASSERT_IMP(a_done_expected, clock, reset, any_done, (state_ff == ST_RUN) && wait_ff)
   // running distance never goes down
   `THODO_ASSERT_NXT(a_dist_monotonic, clock, reset, finish, distance_ff >= $past(distance_ff))

endmodule

`default_nettype wire
